// ===== hw/rtl/rfafc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rfafc_pkg
// Types, framing codes and the character decoder shared by the RFID ASCII
// frame checker and its channel interfaces.
// ----------------------------------------------------------------------------
package rfafc_pkg;

  localparam int TAG_W = 40;

  typedef logic [7:0]       byte_t;
  typedef logic [TAG_W-1:0] tag_t;

  // Framing bytes of the reader's serial protocol
  localparam byte_t START_BYTE = 8'h02;
  localparam byte_t END_BYTE   = 8'h03;

  // ASCII codes that bound the hex digit ranges
  localparam byte_t CHAR_0 = 8'd48;
  localparam byte_t CHAR_9 = 8'd57;
  localparam byte_t CHAR_A = 8'd65;
  localparam byte_t CHAR_F = 8'd70;
  localparam byte_t ALPHA_OFS = 8'd55;

  // Map an ASCII hex digit to its value; other characters keep their code
  function automatic byte_t hex_nibble(input byte_t c);
    byte_t v;
    v = c;
    if (c >= CHAR_A && c <= CHAR_F) begin
      v = c - ALPHA_OFS;
    end else if (c >= CHAR_0 && c <= CHAR_9) begin
      v = c - CHAR_0;
    end
    return v;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/rfafc_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rfafc channel interfaces
// Valid/ready channels for received serial bytes and for frame results.
// ----------------------------------------------------------------------------
interface rfafc_in_if;
  logic             valid;
  logic             ready;
  rfafc_pkg::byte_t rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface rfafc_out_if;
  logic             valid;
  logic             ready;
  rfafc_pkg::tag_t  tag_id;
  rfafc_pkg::byte_t received_check;
  logic             accepted;
  logic             short_frame;

  modport source (output valid, output tag_id, output received_check,
                  output accepted, output short_frame, input ready);
  modport sink   (input valid, input tag_id, input received_check,
                  input accepted, input short_frame, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/rfid_ascii_frame_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rfid_ascii_frame_checker
// Parses ASCII hex frames from an RFID reader, assembles the tag bytes and
// checks the XOR checksum carried in the frame.
// ----------------------------------------------------------------------------
//  channel   direction  beat contents
//  in_ch     sink       rx_byte: one received serial byte
//  out_ch    source     tag_id, received_check, accepted, short_frame
//
//  A byte enters an input register, then decode logic updates the frame
//  state; when that byte is an end byte, the output register loads the result.
//  Sustained rate is one byte per cycle, limited only by the output register
//  when a result beat is not taken. Reset (rst_n low, synchronous) returns
//  to idle and drops any held beat. An end byte waits in the input register
//  while the output register is full, and the input stalls behind it.
// ----------------------------------------------------------------------------
module rfid_ascii_frame_checker #(
  parameter int DATA_BYTES = 5
) (
  input  wire              clk,
  input  wire              rst_n,
  rfafc_in_if.sink         in_ch,
  rfafc_out_if.source      out_ch
);
  import rfafc_pkg::*;

  localparam int FRAME_CHARS = 2 * (DATA_BYTES + 1);
  localparam int CNT_W       = $clog2(FRAME_CHARS + 1);

  // Input register
  logic  stg_valid_r;
  byte_t stg_byte_r;

  // Frame state
  logic             in_frame_r;
  logic [CNT_W-1:0] cnt_r;
  byte_t            hi_r;
  byte_t            xor_r;
  tag_t             tag_r;
  byte_t            chk_r;

  // Result register
  logic  out_valid_r;
  tag_t  out_tag_r;
  byte_t out_chk_r;
  logic  out_acc_r;
  logic  out_short_r;

  logic  is_result;
  logic  out_free;
  logic  stg_adv;
  logic  full;
  byte_t nib;
  byte_t pair_byte;

  // Decide whether the staged beat moves on this cycle
  always_comb begin
    is_result = in_frame_r && (stg_byte_r == END_BYTE);
    out_free  = !out_valid_r || out_ch.ready;
    stg_adv   = stg_valid_r && (!is_result || out_free);
    full      = (cnt_r >= CNT_W'(FRAME_CHARS));
    nib       = hex_nibble(stg_byte_r);
    pair_byte = byte_t'({hi_r[3:0], 4'h0} + nib);
  end

  assign in_ch.ready = !stg_valid_r || stg_adv;

  // Hold the incoming beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
      stg_byte_r  <= '0;
    end else if (in_ch.ready) begin
      stg_valid_r <= in_ch.valid;
      stg_byte_r  <= in_ch.rx_byte;
    end
  end

  // Advance the frame state for one character
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
      cnt_r      <= '0;
      hi_r       <= '0;
      xor_r      <= '0;
      tag_r      <= '0;
      chk_r      <= '0;
    end else if (stg_adv) begin
      if (!in_frame_r) begin
        if (stg_byte_r == START_BYTE) begin
          in_frame_r <= 1'b1;
          cnt_r      <= '0;
          hi_r       <= '0;
          xor_r      <= '0;
          tag_r      <= '0;
          chk_r      <= '0;
        end
      end else if (is_result) begin
        in_frame_r <= 1'b0;
      end else if (!full) begin
        if (!cnt_r[0]) begin
          hi_r <= nib;
        end else if ((cnt_r >> 1) < CNT_W'(DATA_BYTES)) begin
          xor_r <= xor_r ^ pair_byte;
          tag_r <= {tag_r[TAG_W-9:0], pair_byte};
        end else begin
          chk_r <= pair_byte;
        end
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  // Load the result at the end byte, drop it once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      out_tag_r   <= '0;
      out_chk_r   <= '0;
      out_acc_r   <= 1'b0;
      out_short_r <= 1'b0;
    end else if (stg_adv && is_result) begin
      out_valid_r <= 1'b1;
      out_tag_r   <= tag_r;
      out_chk_r   <= chk_r;
      out_acc_r   <= full && (xor_r == chk_r);
      out_short_r <= !full;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.tag_id         = out_tag_r;
  assign out_ch.received_check = out_chk_r;
  assign out_ch.accepted       = out_acc_r;
  assign out_ch.short_frame    = out_short_r;

  // Checks
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(FRAME_CHARS))
    else $error("character count passed frame length");

  a_acc_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_acc_r && out_short_r))
    else $error("short frame flagged as accepted");

  a_end_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (stg_adv && is_result) |=> (!in_frame_r && out_valid_r))
    else $error("end byte did not close frame and load result");

  a_no_lost: assert property (@(posedge clk) disable iff (!rst_n)
    (stg_valid_r && is_result && !out_free) |=> (stg_valid_r && $stable(stg_byte_r)))
    else $error("end byte dropped while result pending");

endmodule
`default_nettype wire
